@@ rtl/core/smlo_pkg.sv @@
`default_nettype none

package smlo_pkg;

	// Default geometry of the store
	localparam int SMLO_CAPACITY   = 16;
	localparam int SMLO_INDEX_BITS = 16;

	// Fixed field widths of the request and response words
	localparam int ORBITAL_W = 16;
	localparam int AMP_W     = 15;
	localparam int COUNT_W   = 5;

	// Amplitude lookup covers multiplicities 0 to 64
	localparam int AMP_IDX_W  = 7;
	localparam int AMP_DEPTH  = 65;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// round(4096 * sqrt(m)), saturated to the field
	localparam logic [AMP_W-1:0] AMP_TABLE [0:AMP_DEPTH-1] = '{
		15'd0,     15'd4096,  15'd5793,  15'd7094,  15'd8192,
		15'd9159,  15'd10033, 15'd10837, 15'd11585, 15'd12288,
		15'd12953, 15'd13585, 15'd14189, 15'd14768, 15'd15326,
		15'd15864, 15'd16384, 15'd16888, 15'd17378, 15'd17854,
		15'd18318, 15'd18770, 15'd19212, 15'd19644, 15'd20066,
		15'd20480, 15'd20886, 15'd21283, 15'd21674, 15'd22058,
		15'd22435, 15'd22806, 15'd23170, 15'd23530, 15'd23884,
		15'd24232, 15'd24576, 15'd24915, 15'd25249, 15'd25580,
		15'd25905, 15'd26227, 15'd26545, 15'd26859, 15'd27170,
		15'd27477, 15'd27780, 15'd28081, 15'd28378, 15'd28672,
		15'd28963, 15'd29251, 15'd29537, 15'd29819, 15'd30099,
		15'd30377, 15'd30652, 15'd30924, 15'd31194, 15'd31462,
		15'd31727, 15'd31991, 15'd32252, 15'd32511, 15'd32767
	};

	// Update command broadcast to every cell in the row
	typedef struct packed {
		logic ins;
		logic del;
	} smlo_upd_t;

	// Clamp a count to the 5-bit response field
	function automatic logic [COUNT_W-1:0] sat_count(input logic [AMP_IDX_W-1:0] v);
		logic [COUNT_W-1:0] r;
		if (v > AMP_IDX_W'(COUNT_MAX)) begin
			r = COUNT_MAX;
		end else begin
			r = v[COUNT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/smlo_cell.sv @@
`default_nettype none

module smlo_cell #(
	parameter int INDEX_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmp_en,
	input  wire                   occupied,
	input  wire  [INDEX_BITS-1:0] idx_s1,
	input  wire  [INDEX_BITS-1:0] idx_s2,
	input  smlo_pkg::smlo_upd_t   upd,
	input  wire                   le_prev,
	input  wire                   le_next,
	input  wire  [INDEX_BITS-1:0] entry_prev,
	input  wire  [INDEX_BITS-1:0] entry_next,
	output logic [INDEX_BITS-1:0] entry,
	output logic                  le,
	output logic                  eq
);
	import smlo_pkg::*;

	logic [INDEX_BITS-1:0] entry_q;
	logic                  le_s2;
	logic                  eq_s2;
	logic [INDEX_BITS-1:0] entry_d;

	// Capture compare flags against the broadcast index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_s2 <= 1'b0;
			eq_s2 <= 1'b0;
		end else if (cmp_en) begin
			le_s2 <= occupied && (entry_q <= idx_s1);
			eq_s2 <= occupied && (entry_q == idx_s1);
		end
	end

	// Insert: keep below the slot, drop the index in, shift up above it.
	// Remove: keep below the last equal copy, pull from the right neighbor.
	always_comb begin
		entry_d = entry_q;
		if (upd.ins) begin
			if (le_s2) begin
				entry_d = entry_q;
			end else if (le_prev) begin
				entry_d = idx_s2;
			end else begin
				entry_d = entry_prev;
			end
		end else if (upd.del) begin
			if (le_next) begin
				entry_d = entry_q;
			end else begin
				entry_d = entry_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign le    = le_s2;
	assign eq    = eq_s2;

endmodule

`default_nettype wire

@@ rtl/core/sorted_multiset_ladder_ops.sv @@
`default_nettype none

// Sorted multiset of orbital indices held in a row of CAPACITY cells, one
// entry per cell in ascending order. A request word is taken when req_ready
// is high, which it is whenever no earlier word is still in the row. A word
// passes the index register, the compare stage in the cells and the update
// stage that shifts the row and loads the response register, and the next
// word is taken only after the previous one has left the update stage. A
// response left waiting on rsp_ready holds the update stage, and with it the
// next word.
// A create on a full store changes nothing and reports overflow; an annihilate
// of an absent index empties the store and reports vanished. Orbital bits
// above INDEX_BITS are ignored.
module sorted_multiset_ladder_ops #(
	parameter int CAPACITY   = smlo_pkg::SMLO_CAPACITY,
	parameter int INDEX_BITS = smlo_pkg::SMLO_INDEX_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_ready,
	input  wire                            mode,
	input  wire  [smlo_pkg::ORBITAL_W-1:0] orbital,
	output logic                           rsp_valid,
	input  wire                            rsp_ready,
	output logic [smlo_pkg::AMP_W-1:0]     amplitude,
	output logic [smlo_pkg::COUNT_W-1:0]   multiplicity,
	output logic [smlo_pkg::COUNT_W-1:0]   occupancy,
	output logic                           vanished,
	output logic                           overflow
);
	import smlo_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);

	logic                  s1_v_q;
	logic                  s2_v_q;
	logic                  mode_s1;
	logic                  mode_s2;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [INDEX_BITS-1:0] idx_s2;
	logic [FILL_W-1:0]     fill_q;

	logic [INDEX_BITS-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]   le_w;
	logic [CAPACITY-1:0]   eq_w;

	logic                  req_fire;
	logic                  s2_fire;
	smlo_upd_t             upd;

	logic [FILL_W-1:0]     eq_cnt;
	logic [FILL_W-1:0]     mult_d;
	logic [FILL_W-1:0]     fill_d;
	logic                  vanished_d;
	logic                  overflow_d;

	logic                  rsp_v_q;
	logic [AMP_W-1:0]      amplitude_q;
	logic [COUNT_W-1:0]    multiplicity_q;
	logic [COUNT_W-1:0]    occupancy_q;
	logic                  vanished_q;
	logic                  overflow_q;

	assign req_ready = !s1_v_q && !s2_v_q;
	assign req_fire  = req_valid && req_ready;
	assign s2_fire   = s2_v_q && (!rsp_v_q || rsp_ready);

	// Advance the word through the index and compare stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			s1_v_q <= req_fire;
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (s2_fire) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_s1 <= mode;
			idx_s1  <= orbital[INDEX_BITS-1:0];
		end
		if (s1_v_q) begin
			mode_s2 <= mode_s1;
			idx_s2  <= idx_s1;
		end
	end

	// Count equal copies from the registered flags
	always_comb begin
		eq_cnt = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			eq_cnt = eq_cnt + FILL_W'(eq_w[k]);
		end
	end

	// Decide the outcome of the word in the update stage
	always_comb begin
		upd        = '0;
		mult_d     = '0;
		fill_d     = fill_q;
		vanished_d = 1'b0;
		overflow_d = 1'b0;
		if (mode_s2) begin
			if (fill_q == FILL_W'(CAPACITY)) begin
				overflow_d = 1'b1;
			end else begin
				upd.ins = s2_fire;
				mult_d  = eq_cnt + FILL_W'(1);
				fill_d  = fill_q + FILL_W'(1);
			end
		end else begin
			if (eq_cnt == '0) begin
				vanished_d = 1'b1;
				fill_d     = '0;
			end else begin
				upd.del = s2_fire;
				mult_d  = eq_cnt;
				fill_d  = fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (s2_fire) begin
			fill_q <= fill_d;
		end
	end

	// Row of cells, each talking only to its two neighbors
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic                  le_prev;
		logic                  le_next;
		logic [INDEX_BITS-1:0] entry_prev;
		logic [INDEX_BITS-1:0] entry_next;

		if (k == 0) begin : g_first
			assign le_prev    = 1'b1;
			assign entry_prev = idx_s2;
		end else begin : g_inner_prev
			assign le_prev    = le_w[k-1];
			assign entry_prev = entry_w[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign le_next    = 1'b0;
			assign entry_next = entry_w[k];
		end else begin : g_inner_next
			assign le_next    = le_w[k+1];
			assign entry_next = entry_w[k+1];
		end

		smlo_cell #(
			.INDEX_BITS(INDEX_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (s1_v_q),
			.occupied   (fill_q > FILL_W'(k)),
			.idx_s1     (idx_s1),
			.idx_s2     (idx_s2),
			.upd        (upd),
			.le_prev    (le_prev),
			.le_next    (le_next),
			.entry_prev (entry_prev),
			.entry_next (entry_next),
			.entry      (entry_w[k]),
			.le         (le_w[k]),
			.eq         (eq_w[k])
		);
	end

	// Hold the response word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (s2_fire) begin
			rsp_v_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			amplitude_q    <= AMP_TABLE[AMP_IDX_W'(mult_d)];
			multiplicity_q <= sat_count(AMP_IDX_W'(mult_d));
			occupancy_q    <= sat_count(AMP_IDX_W'(fill_d));
			vanished_q     <= vanished_d;
			overflow_q     <= overflow_d;
		end
	end

	assign rsp_valid    = rsp_v_q;
	assign amplitude    = amplitude_q;
	assign multiplicity = multiplicity_q;
	assign occupancy    = occupancy_q;
	assign vanished     = vanished_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire
